FILE: src/tausworthe_word_generator_top_defines.svh
// assertion macros used by the sequencer module tw_ctrl
`ifndef TAUSWORTHE_WORD_GENERATOR_TOP_DEFINES_SVH
`define TAUSWORTHE_WORD_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tausworthe generator check failed");

// next-cycle implication, disabled during reset
`define TW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tausworthe generator check failed");

`endif

FILE: src/tw_pkg.sv
package tw_pkg;

    // register file layout
    localparam int REG_W      = 32;
    localparam int ORDER_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int SEED_BITS  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP  = 2'd3;

    // register reset values
    localparam logic [ORDER_W-1:0] ORDER_RST = 6'd1;
    localparam logic [REG_W-1:0]   TAPS_RST  = 32'd1;
    localparam logic [REG_W-1:0]   SEED_RST  = 32'd1;
    localparam logic [REG_W-1:0]   SKIP_RST  = 32'd0;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SKIP,
        ST_RUN
    } state_t;

    // controls from sequencer to the cell row
    typedef struct packed {
        logic clear;
        logic step;
    } ctrl_t;

endpackage

FILE: src/tausworthe_word_generator_top.sv
// result beat: valid once the word is assembled after the accepted beat; with
// restart (or first request after reset) skip_count bits are discarded first
// a new request is taken only in idle, once the word is in the output register; one sequence
// bit per cycle through the history cell row; a held result stalls the last bit
// reset: asynchronous active low, restores register defaults and forces a
// seed reload and skip on the first request
module tausworthe_word_generator_top
#(
    parameter int MAX_ORDER = 32,
    parameter int WORD_BITS = 32
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,   // [0] restart
    // output stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((WORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,  // [WORD_BITS-1:0] word
    // register writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tw_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [tw_pkg::REG_W-1:0]              cfg_data
);

    localparam int OUT_W = ((WORD_BITS + 7) / 8) * 8;
    localparam int PW    = $clog2(MAX_ORDER + 1);

    logic [tw_pkg::ORDER_W-1:0] order_reg;
    logic [tw_pkg::REG_W-1:0]   tap_mask_reg;
    logic [tw_pkg::REG_W-1:0]   seed_bits_reg;
    logic [tw_pkg::REG_W-1:0]   skip_count_reg;
    logic [PW-1:0]              position_reg, position_next;

    tw_pkg::ctrl_t        ctrl;
    logic [6:0]           eff_order;
    logic [6:0]           pos_ext;
    logic                 seed_phase;
    logic                 seed_bit;
    logic                 new_bit;
    logic [MAX_ORDER-1:0] hist;
    logic [MAX_ORDER-1:0] prod;
    logic [MAX_ORDER-1:0] tap_en;
    logic [WORD_BITS-1:0] word;

    // register writes, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg      <= tw_pkg::ORDER_RST;
            tap_mask_reg   <= tw_pkg::TAPS_RST;
            seed_bits_reg  <= tw_pkg::SEED_RST;
            skip_count_reg <= tw_pkg::SKIP_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tw_pkg::CFG_ORDER: order_reg      <= cfg_data[tw_pkg::ORDER_W-1:0];
                tw_pkg::CFG_TAPS:  tap_mask_reg   <= cfg_data;
                tw_pkg::CFG_SEED:  seed_bits_reg  <= cfg_data;
                tw_pkg::CFG_SKIP:  skip_count_reg <= cfg_data;
                default:           order_reg      <= order_reg;
            endcase
        end
    end

    // order saturates at the cell count
    assign eff_order = (7'(order_reg) > 7'(MAX_ORDER)) ? 7'(MAX_ORDER) : 7'(order_reg);

    // seed phase: early bits come straight from the seed register
    assign pos_ext    = 7'(position_reg);
    assign seed_phase = pos_ext < eff_order;
    assign seed_bit   = (pos_ext < 7'(tw_pkg::SEED_BITS)) ? seed_bits_reg[pos_ext[4:0]] : 1'b0;
    assign new_bit    = seed_phase ? seed_bit : ^prod;

    always_comb
    begin
        position_next = position_reg;
        if (ctrl.clear)
        begin
            position_next = '0;
        end
        else if (ctrl.step && seed_phase)
        begin
            position_next = PW'(position_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
        end
        else
        begin
            position_reg <= position_next;
        end
    end

    // row of history cells, cell i holds b(j-1-i)
    for (genvar i = 0; i < MAX_ORDER; i++)
    begin : g_cell
        if (i < tw_pkg::REG_W)
        begin : g_tap
            assign tap_en[i] = tap_mask_reg[i] && (7'(i) < eff_order);
        end
        else
        begin : g_notap
            assign tap_en[i] = 1'b0;
        end

        if (i == 0)
        begin : g_head
            tw_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .shift_in (new_bit),
                .tap_en   (tap_en[i]),
                .hist_bit (hist[i]),
                .prod     (prod[i])
            );
        end
        else
        begin : g_body
            tw_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .shift_in (hist[i-1]),
                .tap_en   (tap_en[i]),
                .hist_bit (hist[i]),
                .prod     (prod[i])
            );
        end
    end

    // sequencer, word assembly and output register
    tw_ctrl
    #(
        .WORD_BITS (WORD_BITS)
    )
    u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .restart    (s_tdata[0]),
        .skip_count (skip_count_reg),
        .new_bit    (new_bit),
        .ctrl       (ctrl),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_word   (word)
    );

    assign m_tdata = OUT_W'(word);

endmodule

FILE: src/tw_cell.sv
module tw_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  tw_pkg::ctrl_t ctrl,
    input  logic          shift_in,
    input  logic          tap_en,
    output logic          hist_bit,
    output logic          prod
);

    logic hist_reg;
    logic hist_next;

    // clear on restart, take neighbour bit on each step
    always_comb
    begin
        hist_next = hist_reg;
        if (ctrl.clear)
        begin
            hist_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            hist_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= 1'b0;
        end
        else
        begin
            hist_reg <= hist_next;
        end
    end

    // tapped contribution to the feedback parity
    assign hist_bit = hist_reg;
    assign prod     = hist_reg & tap_en;

endmodule

FILE: src/tw_ctrl.sv
`include "tausworthe_word_generator_top_defines.svh"

module tw_ctrl
#(
    parameter int WORD_BITS = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       restart,
    input  logic [tw_pkg::REG_W-1:0]   skip_count,
    input  logic                       new_bit,
    output tw_pkg::ctrl_t              ctrl,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [WORD_BITS-1:0]       out_word
);

    localparam int BCW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam logic [BCW-1:0] LAST_BIT = BCW'(WORD_BITS - 1);

    tw_pkg::state_t state_reg, state_next;
    logic                     primed_reg, primed_next;
    logic [tw_pkg::REG_W-1:0] skip_cnt_reg, skip_cnt_next;
    logic [BCW-1:0]           bit_cnt_reg, bit_cnt_next;
    logic [WORD_BITS-1:0]     word_reg, word_next;
    logic [WORD_BITS-1:0]     out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;

    logic accept;
    logic do_restart;
    logic last_bit;
    logic out_free;
    logic [WORD_BITS-1:0] word_shifted;

    assign accept       = in_valid && in_ready;
    assign do_restart   = restart || !primed_reg;
    assign last_bit     = (bit_cnt_reg == LAST_BIT);
    assign out_free     = !out_valid_reg || out_ready;
    assign word_shifted = (word_reg << 1) | WORD_BITS'(new_bit);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = do_restart ? tw_pkg::ST_SKIP : tw_pkg::ST_RUN;
                end
            end
            tw_pkg::ST_SKIP:
            begin
                if (skip_cnt_reg == '0)
                begin
                    state_next = tw_pkg::ST_RUN;
                end
            end
            tw_pkg::ST_RUN:
            begin
                if (last_bit && out_free)
                begin
                    state_next = tw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tw_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        in_ready       = 1'b0;
        ctrl.clear     = 1'b0;
        ctrl.step      = 1'b0;
        primed_next    = primed_reg;
        skip_cnt_next  = skip_cnt_reg;
        bit_cnt_next   = bit_cnt_reg;
        word_next      = word_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            tw_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                bit_cnt_next = '0;
                if (in_valid && do_restart)
                begin
                    ctrl.clear    = 1'b1;
                    primed_next   = 1'b1;
                    skip_cnt_next = skip_count;
                end
            end
            tw_pkg::ST_SKIP:
            begin
                // discard one sequence bit per cycle
                if (skip_cnt_reg != '0)
                begin
                    ctrl.step     = 1'b1;
                    skip_cnt_next = skip_cnt_reg - 1'b1;
                end
            end
            tw_pkg::ST_RUN:
            begin
                // the final bit waits until the output register is free
                if (!last_bit || out_free)
                begin
                    ctrl.step    = 1'b1;
                    word_next    = word_shifted;
                    bit_cnt_next = BCW'(bit_cnt_reg + 1'b1);
                    if (last_bit)
                    begin
                        out_next       = word_shifted;
                        out_valid_next = 1'b1;
                    end
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tw_pkg::ST_IDLE;
            primed_reg    <= 1'b0;
            skip_cnt_reg  <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            primed_reg    <= primed_next;
            skip_cnt_reg  <= skip_cnt_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // checks
    `TW_ASSERT_NOW(a_clear_not_step, clk, rst_n, ctrl.clear, !ctrl.step)
    `TW_ASSERT_NEXT(a_last_bit_loads_out, clk, rst_n,
        (state_reg == tw_pkg::ST_RUN) && last_bit && ctrl.step, out_valid_reg)
    `TW_ASSERT_NEXT(a_primed_goes_run, clk, rst_n,
        accept && primed_reg && !restart, state_reg == tw_pkg::ST_RUN)
    `TW_ASSERT_NEXT(a_skip_counts_down, clk, rst_n,
        (state_reg == tw_pkg::ST_SKIP) && (skip_cnt_reg != '0),
        skip_cnt_reg == $past(skip_cnt_reg) - 1'b1)

endmodule

FILE: tb/sv/tb_tausworthe_word_generator_top.sv
`timescale 1ns / 100ps

module tb_tausworthe_word_generator_top;

    import tw_pkg::*;

    localparam int MAX_ORDER   = 32;
    localparam int WORD_BITS   = 32;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int IDLE_PCT    = 34;
    localparam int HOLD_CYCLES = 400;
    localparam int LONG_SKIP   = 50_000;

    // running copy of the generator: registers, history and expected words
    class tausworthe_words;
        logic [ORDER_W-1:0]   order_reg;
        logic [REG_W-1:0]     taps_reg;
        logic [REG_W-1:0]     seed_reg;
        logic [REG_W-1:0]     skip_reg;
        logic [MAX_ORDER-1:0] history;
        int unsigned          seeded;
        bit                   primed;
        logic [WORD_BITS-1:0] pending_words[$];
        int                   bad_words;
        int                   words_seen;

        function new();
            order_reg  = ORDER_RST;
            taps_reg   = TAPS_RST;
            seed_reg   = SEED_RST;
            skip_reg   = SKIP_RST;
            history    = '0;
            seeded     = 0;
            primed     = 1'b0;
            bad_words  = 0;
            words_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
            case (idx)
                CFG_ORDER: order_reg = val[ORDER_W-1:0];
                CFG_TAPS:  taps_reg  = val;
                CFG_SEED:  seed_reg  = val;
                CFG_SKIP:  skip_reg  = val;
                default:   ;
            endcase
        endfunction

        // one sequence bit: seed bits first, then parity of the tapped history
        function logic next_bit();
            int unsigned          k;
            logic [MAX_ORDER-1:0] live_taps;
            logic                 b;
            k = (order_reg > MAX_ORDER) ? MAX_ORDER : order_reg;
            live_taps = (k >= MAX_ORDER) ? taps_reg : taps_reg & ((32'd1 << k) - 32'd1);
            if (seeded < k)
            begin
                b = seed_reg[seeded];
                seeded++;
            end
            else
            begin
                b = ^(history & live_taps);
            end
            history = {history[MAX_ORDER-2:0], b};
            return b;
        endfunction

        // accepted request: reload and skip when needed, then pack one word
        function void note_request(bit restart);
            logic [WORD_BITS-1:0] w;
            longint unsigned      n;
            logic                 dropped;
            w = '0;
            if (restart || !primed)
            begin
                history = '0;
                seeded  = 0;
                for (n = 0; n < skip_reg; n++)
                    dropped = next_bit();
                primed = 1'b1;
            end
            for (int i = 0; i < WORD_BITS; i++)
                w = {w[WORD_BITS-2:0], next_bit()};
            pending_words.push_back(w);
        endfunction

        task report(string what, logic [WORD_BITS-1:0] got, logic [WORD_BITS-1:0] want);
            $display("mismatch: %s, got %08h expected %08h", what, got, want);
            bad_words++;
        endtask

        task check_word(logic [WORD_BITS-1:0] got);
            logic [WORD_BITS-1:0] want;
            words_seen++;
            if (pending_words.size() == 0)
            begin
                report("word with no request pending", got, '0);
            end
            else
            begin
                want = pending_words.pop_front();
                if (got !== want)
                    report("word", got, want);
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [7:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [((WORD_BITS + 7) / 8) * 8 - 1:0] m_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0] cfg_data;

    tausworthe_words gen_words = new();

    bit request_plan[$];
    bit calm;
    bit hold_wanted;
    int hold_left;
    int pressure_at;
    int requests_sent;
    int restarts_sent;
    int settings_used;
    int cycle_count;

    tausworthe_word_generator_top #(
        .MAX_ORDER(MAX_ORDER),
        .WORD_BITS(WORD_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver: random stalls, calm stretches and one long hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_wanted)
            begin
                hold_wanted = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (calm)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // result beats
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            gen_words.check_word(m_tdata[WORD_BITS-1:0]);
    end

    // send every planned request, one beat each, with random gaps
    task issue_requests();
        bit r;
        while (request_plan.size() > 0)
        begin
            r = request_plan.pop_front();
            @(negedge clk);
            while (!calm && $urandom_range(0, 99) < IDLE_PCT)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {7'd0, r};
            do
                @(posedge clk);
            while (!s_tready);
            gen_words.note_request(r);
            requests_sent++;
            if (r)
                restarts_sent++;
            if (requests_sent == pressure_at)
                hold_wanted = 1'b1;
        end
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        gen_words.write_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait for every outstanding word, then let the block go quiet
    task settle();
        while (gen_words.pending_words.size() != 0)
            @(posedge clk);
        repeat (WORD_BITS + 4) @(posedge clk);
    endtask

    task configure(input logic [REG_W-1:0] ord, input logic [REG_W-1:0] taps,
                   input logic [REG_W-1:0] seed, input logic [REG_W-1:0] skip);
        settle();
        write_reg(CFG_ORDER, ord);
        write_reg(CFG_TAPS, taps);
        write_reg(CFG_SEED, seed);
        write_reg(CFG_SKIP, skip);
        settings_used++;
    endtask

    // skip walks one bit per cycle, so most skips are short
    function logic [REG_W-1:0] pick_skip();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 64);
        else if (r < 95)
            return $urandom_range(65, 600);
        return $urandom_range(601, 3000);
    endfunction

    function logic [REG_W-1:0] pick_order();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        else if (r < 20)
            return $urandom_range(MAX_ORDER + 1, 63);
        return $urandom_range(1, MAX_ORDER);
    endfunction

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        calm        = 1'b0;
        hold_wanted = 1'b0;
        hold_left   = 0;
        pressure_at = -1;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: first request reloads even without restart
        request_plan = '{1'b0, 1'b0, 1'b1};
        issue_requests();

        // order zero gives an all-zero stream
        configure(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        request_plan = '{1'b1, 1'b0};
        issue_requests();

        // full order, all taps and seed bits set
        configure(MAX_ORDER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        request_plan = '{1'b0, 1'b1};
        issue_requests();

        // order above the maximum saturates
        configure(63, 32'h8000_0001, 32'hA5A5_A5A5, 1);
        request_plan = '{1'b1, 1'b0};
        issue_requests();
        configure(MAX_ORDER + 1, 0, 0, 0);
        request_plan = '{1'b1};
        issue_requests();

        // skip inside and beyond the seed bits
        configure(5, 32'h0000_0014, 32'h0000_001F, 3);
        request_plan = '{1'b1, 1'b0};
        issue_requests();
        settle();
        write_reg(CFG_SKIP, 40);
        request_plan = '{1'b1};
        issue_requests();

        // one long skip
        configure(31, 32'h4800_0000, $urandom, LONG_SKIP);
        request_plan = '{1'b1, 1'b0};
        issue_requests();

        // random settings and requests, one calm phase, one held receiver
        for (int phase = 0; phase < 10; phase++)
        begin
            configure(pick_order(), $urandom, $urandom, pick_skip());
            calm = (phase == 4);
            if (phase == 6)
                pressure_at = requests_sent + 5;
            for (int i = 0; i < 40; i++)
                request_plan.push_back($urandom_range(0, 99) < 15);
            issue_requests();
        end
        calm = 1'b0;

        settle();
        while (gen_words.pending_words.size() != 0)
            gen_words.report("word never produced", '0, gen_words.pending_words.pop_front());

        $display("%0d requests (%0d restarts) over %0d register settings, %0d words checked",
                 requests_sent, restarts_sent, settings_used, gen_words.words_seen);
        $display("orders 0 to 63, long and short skips, stalls and a long receiver hold");
        if (gen_words.bad_words == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
